FILE: hdl/assert_macros.svh
// Assertion macros shared by the RTL of the insertion sorter.
// No dependencies; the assertions compile away when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// The property must hold at every clock edge while the block is out of reset.
`define ASSERT_HOLDS(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// The expression must never be true while the block is out of reset.
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define ASSERT_HOLDS(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

FILE: hdl/iss_pkg.sv
// Package for the insertion sorter: data width, default depth, cell control type
// and controller state codes. No dependencies.
package iss_pkg;

  localparam int unsigned DataWidth    = 32;
  localparam int unsigned DefaultDepth = 64;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic insert;  // place the broadcast value into the list
    logic shift;   // move every entry one cell towards the output
  } cell_ctl_t;

  typedef enum logic [1:0] {
    StFill  = 2'b01,
    StDrain = 2'b10
  } iss_state_e;

endpackage

FILE: hdl/insertion_sorter_unit.sv
// Top level of the streaming insertion sorter: the controller and a chain of
// DEPTH compare-and-shift cells. Depends on iss_pkg, iss_cell, assert_macros.svh.
`include "assert_macros.svh"

// The sorter collects a set of signed 32-bit values, one per input item, and
// keeps them in ascending order in a chain of DEPTH cells. Every cell compares
// the incoming value with its own entry; the cells whose entries are greater
// move one place up in the same cycle and the value drops into the gap, so a
// new item is taken every cycle while a set is being filled. Values equal to
// a held entry go behind it, which makes the sort stable. Once the item
// flagged last has been placed, the chain empties towards its first cell, one
// result item per accepted output cycle, with end_of_set on the final one.
// The input is stalled while the results of a set are sent out. Values
// arriving when all DEPTH cells are full are dropped, and every result of
// that set then carries the overflow flag. There is no start-up clearing
// pass: the first item may be sent in the first cycle after reset.
module insertion_sorter_unit #(
  parameter int unsigned DEPTH = iss_pkg::DefaultDepth
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [iss_pkg::DataWidth-1:0] value_i,
  input  logic                                 last_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [iss_pkg::DataWidth-1:0] sorted_value_o,
  output logic                                 end_of_set_o,
  output logic                                 overflow_o
);
  import iss_pkg::*;

  iss_state_e state_q, state_d;
  logic       dropped_q, dropped_d;

  logic in_acc, out_acc, full;
  cell_ctl_t ctl;

  logic signed [DataWidth-1:0] cell_value [DEPTH];
  logic [DEPTH-1:0]            cell_occ;
  logic [DEPTH-1:0]            cell_gt;

  // Input is taken only while filling; the chain is busy while it drains.
  assign in_stall_o = (state_q != StFill);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_o && !out_stall_i;

  // With cells filled contiguously from the first, the last cell tells us
  // whether the list is full.
  assign full       = cell_occ[DEPTH-1];
  assign ctl.insert = in_acc && !full;
  assign ctl.shift  = out_acc;

  // The chain of cells. The first cell sees an always-occupied, never-greater
  // neighbour on its left; the last sees an empty neighbour on its right.
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic signed [DataWidth-1:0] left_value, right_value;
    logic                        left_gt, left_occ, right_occ;

    if (k == 0) begin : g_first
      assign left_value = '0;
      assign left_gt    = 1'b0;
      assign left_occ   = 1'b1;
    end else begin : g_inner_left
      assign left_value = cell_value[k-1];
      assign left_gt    = cell_gt[k-1];
      assign left_occ   = cell_occ[k-1];
    end

    if (k == DEPTH - 1) begin : g_last
      assign right_value = '0;
      assign right_occ   = 1'b0;
    end else begin : g_inner_right
      assign right_value = cell_value[k+1];
      assign right_occ   = cell_occ[k+1];
    end

    iss_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctl_i         (ctl),
      .new_value_i   (value_i),
      .left_value_i  (left_value),
      .left_gt_i     (left_gt),
      .left_occ_i    (left_occ),
      .right_value_i (right_value),
      .right_occ_i   (right_occ),
      .value_o       (cell_value[k]),
      .occ_o         (cell_occ[k]),
      .gt_o          (cell_gt[k])
    );
  end

  // Results come straight from the first cell, which holds steady while the
  // output is stalled because the chain only shifts on an accepted result.
  assign out_valid_o    = (state_q == StDrain) && cell_occ[0];
  assign sorted_value_o = cell_value[0];
  assign end_of_set_o   = !cell_occ[1];
  assign overflow_o     = dropped_q;

  always_comb begin
    state_d   = state_q;
    dropped_d = dropped_q;
    case (state_q)
      StFill: begin
        if (in_acc) begin
          dropped_d = dropped_q | full;
          if (last_i) begin
            state_d = StDrain;
          end
        end
      end
      StDrain: begin
        if (out_acc && end_of_set_o) begin
          state_d   = StFill;
          dropped_d = 1'b0;
        end
      end
      default: begin
        state_d   = StFill;
        dropped_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StFill;
      dropped_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      dropped_q <= dropped_d;
    end
  end

  // Checking aids: the held entries must form an ascending prefix of the chain.
  logic [DEPTH-1:0] order_ok;
  assign order_ok[0] = 1'b1;
  for (genvar k = 1; k < DEPTH; k++) begin : g_order
    assign order_ok[k] = !cell_occ[k] || (cell_value[k] >= cell_value[k-1]);
  end

  `ASSERT_NEVER(a_occ_prefix, clk_i, rst_ni, ((cell_occ >> 1) & ~cell_occ) != '0,
    "occupied cells do not form a contiguous prefix")
  `ASSERT_HOLDS(a_ascending, clk_i, rst_ni, &order_ok,
    "held entries are not in ascending order")
  `ASSERT_HOLDS(a_empty_after_set, clk_i, rst_ni,
    (out_acc && end_of_set_o) |=> (cell_occ == '0) && !dropped_q,
    "chain or overflow flag not cleared after the final result of a set")
  `ASSERT_HOLDS(a_drop_flagged, clk_i, rst_ni, (in_acc && full) |=> dropped_q,
    "item dropped on a full chain without raising overflow")

endmodule

FILE: hdl/iss_cell.sv
// One compare-and-shift cell of the insertion sorter chain.
// Depends on iss_pkg.
module iss_cell (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  iss_pkg::cell_ctl_t                   ctl_i,
  input  logic signed [iss_pkg::DataWidth-1:0] new_value_i,
  input  logic signed [iss_pkg::DataWidth-1:0] left_value_i,
  input  logic                                 left_gt_i,
  input  logic                                 left_occ_i,
  input  logic signed [iss_pkg::DataWidth-1:0] right_value_i,
  input  logic                                 right_occ_i,
  output logic signed [iss_pkg::DataWidth-1:0] value_o,
  output logic                                 occ_o,
  output logic                                 gt_o
);
  import iss_pkg::*;

  logic signed [DataWidth-1:0] value_q, value_d;
  logic                        occ_q, occ_d;

  // Strictly greater keeps equal values in arrival order.
  assign gt_o = occ_q && (value_q > new_value_i);

  always_comb begin
    value_d = value_q;
    occ_d   = occ_q;
    if (ctl_i.shift) begin
      value_d = right_value_i;
      occ_d   = right_occ_i;
    end else if (ctl_i.insert) begin
      if (left_gt_i) begin
        value_d = left_value_i;
      end else if (gt_o || (!occ_q && left_occ_i)) begin
        value_d = new_value_i;
      end
      occ_d = occ_q | left_occ_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign occ_o   = occ_q;

endmodule
